@@ sv/fgce_pkg.sv @@
// Shared types and constants of the functional graph cycle-entry block.
package fgce_pkg;

   localparam int NODE_W            = 10;
   localparam int CNT_W             = 11;
   localparam int MAX_NODES_DEFAULT = 1024;
   localparam int NODE_COUNT_RESET  = 1024;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [1:0] {
      T_IDLE,
      T_SOLVE,
      T_LOOK,
      T_SEND
   } top_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLR,
      S_CLR_END,
      S_OUTER,
      S_OUTER_CHK,
      S_W_RD,
      S_W_CHK,
      S_W_SUCC,
      S_CYC_RD,
      S_CYC_NX,
      S_P_TOP,
      S_P_U,
      S_P_S,
      S_P_W,
      S_NEXT
   } solve_state_type;

   typedef struct packed {
      logic valid;
      logic visited;
   } flag_type;

   typedef struct packed {
      logic busy;
      logic range_err;
   } solve_status_type;

endpackage

@@ sv/fgce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fgce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fgce_solver.sv @@
// Solve sequencer: range check with flag clear, path walk, cycle marking and stack unwind.
module fgce_solver import fgce_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [CNT_W-1:0]             node_count,
   output solve_status_type             status,
   output logic [$clog2(MAX_NODES)-1:0] succ_raddr,
   input  logic [NODE_W-1:0]            succ_rdata,
   output logic [$clog2(MAX_NODES)-1:0] ans_raddr,
   input  logic [NODE_W-1:0]            ans_rdata,
   output logic                         ans_wr_en,
   output logic [$clog2(MAX_NODES)-1:0] ans_waddr,
   output logic [NODE_W-1:0]            ans_wdata
);

   localparam int ADDR_W  = $clog2(MAX_NODES);
   localparam int DEPTH_W = $clog2(MAX_NODES + 1);
   localparam int XW      = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [XW-1:0] x);
      return x[ADDR_W-1:0];
   endfunction

   solve_state_type      state_ff, state_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [NODE_W-1:0]    v_ff, v_in;
   logic [NODE_W-1:0]    s_ff, s_in;
   logic [NODE_W-1:0]    a_ff, a_in;
   logic [CNT_W-1:0]     guard_ff, guard_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic                 err_ff, err_in;
   logic                 chk_ff, chk_in;

   logic [CNT_W-1:0]     i_next;
   logic [CNT_W-1:0]     guard_next;
   logic [DEPTH_W-1:0]   depth_dec;
   logic                 stack_full;
   logic                 err_now;

   logic                 flag_we;
   logic [ADDR_W-1:0]    flag_waddr;
   flag_type             flag_wdata;
   logic [ADDR_W-1:0]    flag_raddr;
   flag_type             flag_rd;

   logic                 stk_we;
   logic [ADDR_W-1:0]    stk_waddr;
   logic [NODE_W-1:0]    stk_wdata;
   logic [ADDR_W-1:0]    stk_raddr;
   logic [NODE_W-1:0]    stk_rdata;

   fgce_ram #(
      .WIDTH ($bits(flag_type)),
      .DEPTH (MAX_NODES)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (flag_raddr),
      .rd_data (flag_rd)
   );

   fgce_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign i_next     = i_ff + 1'b1;
   assign guard_next = guard_ff + 1'b1;
   assign depth_dec  = depth_ff - 1'b1;
   assign stack_full = (depth_ff == DEPTH_W'(MAX_NODES));
   assign err_now    = chk_ff && (CNT_W'(succ_rdata) >= node_count);

   assign status.busy      = (state_ff != S_IDLE);
   assign status.range_err = err_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CLR;
         end
         S_CLR: begin
            if (i_next == node_count) state_in = S_CLR_END;
         end
         S_CLR_END: begin
            state_in = (err_ff || err_now) ? S_IDLE : S_OUTER;
         end
         S_OUTER: begin
            state_in = S_OUTER_CHK;
         end
         S_OUTER_CHK: begin
            state_in = flag_rd.visited ? S_NEXT : S_W_RD;
         end
         S_W_RD: begin
            state_in = S_W_CHK;
         end
         S_W_CHK: begin
            state_in = flag_rd.visited ? S_CYC_RD : S_W_SUCC;
         end
         S_W_SUCC: begin
            state_in = (flag_rd.valid || stack_full) ? S_P_TOP : S_W_RD;
         end
         S_CYC_RD: begin
            state_in = S_CYC_NX;
         end
         S_CYC_NX: begin
            if (succ_rdata == v_ff || guard_next >= node_count) state_in = S_P_TOP;
            else state_in = S_CYC_RD;
         end
         S_P_TOP: begin
            state_in = (depth_ff == '0) ? S_NEXT : S_P_U;
         end
         S_P_U: begin
            state_in = S_P_S;
         end
         S_P_S: begin
            state_in = flag_rd.valid ? S_P_TOP : S_P_W;
         end
         S_P_W: begin
            state_in = S_P_TOP;
         end
         S_NEXT: begin
            state_in = (i_next >= node_count) ? S_IDLE : S_OUTER;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      i_in     = i_ff;
      v_in     = v_ff;
      s_in     = s_ff;
      a_in     = a_ff;
      guard_in = guard_ff;
      depth_in = depth_ff;
      err_in   = err_ff;
      chk_in   = (state_ff == S_CLR);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               i_in   = '0;
               err_in = 1'b0;
            end
         end
         S_CLR: begin
            i_in   = i_next;
            err_in = err_ff | err_now;
         end
         S_CLR_END: begin
            i_in   = '0;
            err_in = err_ff | err_now;
         end
         S_OUTER_CHK: begin
            if (!flag_rd.visited) begin
               v_in     = i_ff[NODE_W-1:0];
               depth_in = '0;
            end
         end
         S_W_CHK: begin
            if (flag_rd.visited) begin
               a_in     = v_ff;
               guard_in = '0;
            end else begin
               s_in = succ_rdata;
            end
         end
         S_W_SUCC: begin
            if (!flag_rd.valid && !stack_full) begin
               depth_in = depth_ff + 1'b1;
               v_in     = s_ff;
            end
         end
         S_CYC_NX: begin
            a_in     = succ_rdata;
            guard_in = guard_next;
         end
         S_P_TOP: begin
            if (depth_ff != '0) depth_in = depth_dec;
         end
         S_P_U: begin
            a_in = stk_rdata;
         end
         S_NEXT: begin
            i_in = i_next;
         end
         default: begin
         end
      endcase
   end

   // memory port control
   always_comb begin
      succ_raddr = to_addr(XW'(v_ff));
      ans_raddr  = to_addr(XW'(succ_rdata));
      ans_wr_en  = 1'b0;
      ans_waddr  = to_addr(XW'(a_ff));
      ans_wdata  = ans_rdata;
      flag_we    = 1'b0;
      flag_waddr = to_addr(XW'(v_ff));
      flag_wdata = '{valid: 1'b1, visited: 1'b1};
      flag_raddr = to_addr(XW'(v_ff));
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[ADDR_W-1:0];
      stk_wdata  = v_ff;
      stk_raddr  = depth_dec[ADDR_W-1:0];
      case (state_ff)
         S_CLR: begin
            succ_raddr = to_addr(XW'(i_ff));
            flag_we    = 1'b1;
            flag_waddr = to_addr(XW'(i_ff));
            flag_wdata = '{valid: 1'b0, visited: 1'b0};
         end
         S_OUTER: begin
            flag_raddr = to_addr(XW'(i_ff));
         end
         S_W_CHK: begin
            if (!flag_rd.visited) begin
               flag_we    = 1'b1;
               flag_wdata = '{valid: 1'b0, visited: 1'b1};
               flag_raddr = to_addr(XW'(succ_rdata));
            end
         end
         S_W_SUCC: begin
            if (flag_rd.valid) begin
               ans_wr_en = 1'b1;
               ans_waddr = to_addr(XW'(v_ff));
               flag_we   = 1'b1;
            end else if (!stack_full) begin
               stk_we = 1'b1;
            end
         end
         S_CYC_RD: begin
            // cycle node answers itself
            ans_wr_en  = 1'b1;
            ans_wdata  = a_ff;
            flag_we    = 1'b1;
            flag_waddr = to_addr(XW'(a_ff));
            succ_raddr = to_addr(XW'(a_ff));
         end
         S_P_U: begin
            flag_raddr = to_addr(XW'(stk_rdata));
            succ_raddr = to_addr(XW'(stk_rdata));
         end
         S_P_W: begin
            ans_wr_en  = 1'b1;
            flag_we    = 1'b1;
            flag_waddr = to_addr(XW'(a_ff));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= 1'b0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         chk_ff   <= chk_in;
      end
      i_ff     <= i_in;
      v_ff     <= v_in;
      s_ff     <= s_in;
      a_ff     <= a_in;
      guard_ff <= guard_in;
      depth_ff <= depth_in;
   end

endmodule

@@ sv/functional_graph_cycle_entry.sv @@
// A load writes the successor table on acceptance. A query on a solved graph reads the answer
// table on acceptance and sends its result from T_SEND once the output register is free; the
// first query after a load or a node_count write first runs a solve: a clear/range scan of all
// n = node_count nodes, then walks over flag, successor, answer and stack RAMs (one write and
// one read port each), then T_LOOK and T_SEND. One transaction is in work at a time. Reset
// clears control state, sets node_count to 1024 (clamped to MAX_NODES).
module functional_graph_cycle_entry import fgce_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [NODE_W-1:0] req_node,
   input  logic [NODE_W-1:0] req_successor,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [NODE_W-1:0] rsp_node_res,
   output logic [NODE_W-1:0] rsp_entry,
   output logic              rsp_error,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data
);

   localparam int ADDR_W   = $clog2(MAX_NODES);
   localparam int XW       = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;
   localparam int NC_RESET = (MAX_NODES < NODE_COUNT_RESET) ? MAX_NODES : NODE_COUNT_RESET;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [XW-1:0] x);
      return x[ADDR_W-1:0];
   endfunction

   top_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  node_count_ff, node_count_in;
   logic              solved_ff, solved_in;
   logic [NODE_W-1:0] node_ff, node_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic [NODE_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic              rsp_error_ff, rsp_error_in;

   logic              req_accept;
   logic              is_query;
   logic              load_hit;
   logic              query_hit;
   logic              out_free;
   logic              solve_start;
   logic              rsp_load;
   logic              ans_sel_req;
   logic              query_err;

   solve_status_type  solve_status;

   logic              succ_we;
   logic [ADDR_W-1:0] succ_waddr;
   logic [ADDR_W-1:0] succ_raddr;
   logic [NODE_W-1:0] succ_rdata;

   logic [ADDR_W-1:0] solver_ans_raddr;
   logic [ADDR_W-1:0] ans_raddr;
   logic [NODE_W-1:0] ans_rdata;
   logic              ans_we;
   logic [ADDR_W-1:0] ans_waddr;
   logic [NODE_W-1:0] ans_wdata;

   // Handshake decode. The block takes a transaction only from idle, but an
   // occupied output register does not hold off the next request.
   assign req_accept = req_valid && !req_stall;
   assign is_query   = (req_action == ACT_QUERY);
   assign load_hit   = req_accept && (req_action == ACT_LOAD);
   assign query_hit  = req_accept && is_query;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Errors: an out-of-range successor seen by the last solve poisons every
   // query; a node at or beyond node_count is answered with an error.
   assign query_err = solve_status.range_err || (CNT_W'(node_ff) >= node_count_ff);

   // Successor table: written by loads, read only by the solver. Loads above
   // the table depth are dropped.
   assign succ_we    = load_hit && (int'(req_node) < MAX_NODES);
   assign succ_waddr = to_addr(XW'(req_node));

   fgce_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_succ_ram (
      .clock   (clock),
      .wr_en   (succ_we),
      .wr_addr (succ_waddr),
      .wr_data (req_successor),
      .rd_addr (succ_raddr),
      .rd_data (succ_rdata)
   );

   // Answer table: the solver owns it while busy; otherwise the query path
   // reads it, straight from the request port on acceptance.
   always_comb begin
      if (solve_status.busy) ans_raddr = solver_ans_raddr;
      else if (ans_sel_req) ans_raddr = to_addr(XW'(req_node));
      else ans_raddr = to_addr(XW'(node_ff));
   end

   fgce_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_ans_ram (
      .clock   (clock),
      .wr_en   (ans_we),
      .wr_addr (ans_waddr),
      .wr_data (ans_wdata),
      .rd_addr (ans_raddr),
      .rd_data (ans_rdata)
   );

   fgce_solver #(
      .MAX_NODES (MAX_NODES)
   ) u_solver (
      .clock      (clock),
      .reset      (reset),
      .start      (solve_start),
      .node_count (node_count_ff),
      .status     (solve_status),
      .succ_raddr (succ_raddr),
      .succ_rdata (succ_rdata),
      .ans_raddr  (solver_ans_raddr),
      .ans_rdata  (ans_rdata),
      .ans_wr_en  (ans_we),
      .ans_waddr  (ans_waddr),
      .ans_wdata  (ans_wdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (query_hit) state_in = solved_ff ? T_SEND : T_SOLVE;
         end
         T_SOLVE: begin
            // solver leaves busy after its last table write
            if (!solve_status.busy) state_in = T_LOOK;
         end
         T_LOOK: begin
            state_in = T_SEND;
         end
         T_SEND: begin
            if (out_free) state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // FSM outputs
   always_comb begin
      req_stall   = 1'b1;
      solve_start = 1'b0;
      rsp_load    = 1'b0;
      ans_sel_req = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            req_stall   = 1'b0;
            ans_sel_req = 1'b1;
            solve_start = query_hit && !solved_ff;
         end
         T_SOLVE: begin
         end
         T_LOOK: begin
         end
         T_SEND: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Configuration, solve bookkeeping and the captured query node.
   always_comb begin
      node_count_in = node_count_ff;
      solved_in     = solved_ff;
      node_in       = node_ff;
      if (csr_wr_en) begin
         // clamp into 1 .. MAX_NODES and force a fresh solve
         if (csr_wr_data == '0) node_count_in = CNT_W'(1);
         else if (int'(csr_wr_data) > MAX_NODES) node_count_in = CNT_W'(MAX_NODES);
         else node_count_in = csr_wr_data;
         solved_in = 1'b0;
      end
      if (load_hit) solved_in = 1'b0;
      if (solve_start) solved_in = 1'b1;
      if (req_accept) node_in = req_node;
   end

   // Output register: load on delivery, drop valid once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_error_in = rsp_error_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_node_in  = node_ff;
         rsp_error_in = query_err;
         rsp_entry_in = query_err ? '0 : ans_rdata;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         node_count_ff <= CNT_W'(NC_RESET);
         solved_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         solved_ff     <= solved_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      node_ff      <= node_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_node_res = rsp_node_ff;
   assign rsp_entry    = rsp_entry_ff;
   assign rsp_error    = rsp_error_ff;

endmodule

@@ tb/functional_graph_cycle_entry_checker.sv @@
// Checker for the cycle-entry block: watches both channels, predicts query answers, compares.
`timescale 1ns / 1ps
module functional_graph_cycle_entry_checker import fgce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_action,
   input  logic [NODE_W-1:0] req_node,
   input  logic [NODE_W-1:0] req_successor,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [NODE_W-1:0] rsp_node_res,
   input  logic [NODE_W-1:0] rsp_entry,
   input  logic              rsp_error,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   output int                open_count,
   output int                fail_count
);

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] entry;
      logic              error;
   } answer_type;

   typedef enum bit [1:0] {UNSEEN, ON_PATH, SETTLED} walk_mark_type;

   answer_type        answers_due[$];
   logic [NODE_W-1:0] next_of[MAX_NODES_DEFAULT];
   logic [NODE_W-1:0] entry_of[MAX_NODES_DEFAULT];
   int unsigned       active_nodes = NODE_COUNT_RESET;
   bit                graph_solved = 1'b0;
   bit                out_of_range = 1'b0;
   int                mismatches = 0;

   assign fail_count = mismatches;

   function automatic int unsigned clamp_nodes(input logic [CNT_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_NODES_DEFAULT) return MAX_NODES_DEFAULT;
      return 32'(v);
   endfunction

   // Recompute the entry node of every node in use. Each walk stops at a node
   // already settled (tail of an earlier walk) or at one on its own path (a loop).
   function automatic void find_entries();
      walk_mark_type mark[MAX_NODES_DEFAULT];
      int            path[$];
      int            i, v, u;
      out_of_range = 1'b0;
      for (i = 0; i < active_nodes; i++)
         if (next_of[i] >= active_nodes) out_of_range = 1'b1;
      if (!out_of_range) begin
         for (i = 0; i < MAX_NODES_DEFAULT; i++) mark[i] = UNSEEN;
         for (i = 0; i < active_nodes; i++) begin
            if (mark[i] == UNSEEN) begin
               v = i;
               while (mark[v] == UNSEEN) begin
                  mark[v] = ON_PATH;
                  path = {path, v};
                  v = int'(next_of[v]);
               end
               // loop closed on this walk: its members answer themselves
               if (mark[v] == ON_PATH) begin
                  u = v;
                  do begin
                     entry_of[u] = NODE_W'(u);
                     mark[u] = SETTLED;
                     u = int'(next_of[u]);
                  end while (u != v);
               end
               while (path.size() > 0) begin
                  u = path[path.size() - 1];
                  path.delete(path.size() - 1);
                  if (mark[u] != SETTLED) begin
                     entry_of[u] = entry_of[next_of[u]];
                     mark[u] = SETTLED;
                  end
               end
            end
         end
      end
      graph_solved = 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns checker: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      answer_type want, seen;
      if (reset) begin
         active_nodes = clamp_nodes(CNT_W'(NODE_COUNT_RESET));
         graph_solved = 1'b0;
         answers_due.delete();
      end else begin
         if (csr_wr_en) begin
            active_nodes = clamp_nodes(csr_wr_data);
            graph_solved = 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_node_res, rsp_entry, rsp_error};
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result for node %0d", seen.node));
            end else begin
               want = answers_due.pop_front();
               if (seen.node != want.node)
                  report_mismatch($sformatf("node_res %0d, expected %0d",
                                            seen.node, want.node));
               if (seen.entry != want.entry)
                  report_mismatch($sformatf("node %0d entry %0d, expected %0d",
                                            want.node, seen.entry, want.entry));
               if (seen.error != want.error)
                  report_mismatch($sformatf("node %0d error %0b, expected %0b",
                                            want.node, seen.error, want.error));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACT_LOAD) begin
               next_of[req_node] = req_successor;
               graph_solved = 1'b0;
            end else begin
               if (!graph_solved) find_entries();
               want.node = req_node;
               if (out_of_range || req_node >= active_nodes) begin
                  want.entry = '0;
                  want.error = 1'b1;
               end else begin
                  want.entry = entry_of[req_node];
                  want.error = 1'b0;
               end
               answers_due = {answers_due, want};
            end
         end
      end
      open_count = answers_due.size();
   end

endmodule

@@ tb/functional_graph_cycle_entry_tb.sv @@
// Top of the cycle-entry testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module functional_graph_cycle_entry_tb;
   import fgce_pkg::*;

   // Stop starting new phases once about this many transactions went out.
   localparam int TOTAL_ITEMS = 1050;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = ACT_LOAD;
   logic [NODE_W-1:0] req_node = '0;
   logic [NODE_W-1:0] req_successor = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [NODE_W-1:0] rsp_node_res;
   logic [NODE_W-1:0] rsp_entry;
   logic              rsp_error;
   logic              csr_wr_en = 1'b0;
   logic [CNT_W-1:0]  csr_wr_data = '0;
   int                open_count;
   int                fail_count;

   // Stimulus bookkeeping: the node count in force, the last successor loaded per
   // node (MAX_NODES_DEFAULT marks a node never loaded), and in-use nodes that
   // were given an out-of-range successor and still need a repair load.
   int unsigned       nodes_in_use = NODE_COUNT_RESET;
   int                next_copy[MAX_NODES_DEFAULT];
   int                broken[$];
   int                sent_items = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   functional_graph_cycle_entry uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_node      (req_node),
      .req_successor (req_successor),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_node_res  (rsp_node_res),
      .rsp_entry     (rsp_entry),
      .rsp_error     (rsp_error),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   functional_graph_cycle_entry_checker entry_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_node      (req_node),
      .req_successor (req_successor),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_node_res  (rsp_node_res),
      .rsp_entry     (rsp_entry),
      .rsp_error     (rsp_error),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .open_count    (open_count),
      .fail_count    (fail_count)
   );

   // Receiver side: stall at random at the current rate; advance at the falling
   // edge so the block sees a settled value at the next rising edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Hard stop: far beyond the slowest legal run (a few full-size solves plus
   // the small-graph bursts under heavy stalling).
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // Offer one transaction, holding it until the block takes it. Called and
   // left at a falling edge; valid stays high so back-to-back items need no gap.
   // The idle rates follow how far the run has got.
   task automatic send(input logic act, input int node, input int succ);
      if (sent_items < TOTAL_ITEMS / 3) begin
         send_idle_pct = 23;
         stall_pct     = 59;
      end else if (sent_items < 2 * TOTAL_ITEMS / 3) begin
         send_idle_pct = 59;
         stall_pct     = 23;
      end else begin
         send_idle_pct = 0;
         stall_pct     = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_action    = act;
      req_node      = NODE_W'(node);
      req_successor = NODE_W'(succ);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (act == ACT_LOAD) next_copy[node] = succ;
      sent_items++;
   endtask

   // Drop valid and wait until every query has been answered, then let the
   // last load settle before anything touches the register.
   task automatic drain();
      req_valid = 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_nodes(input logic [CNT_W-1:0] value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      nodes_in_use = (value == 0) ? 1 :
                     (value > MAX_NODES_DEFAULT) ? MAX_NODES_DEFAULT : value;
   endtask

   // Successor inside the graph; a share of next-node links builds long chains
   // and big loops so walks go deep.
   function automatic int pick_next(input int node);
      if ($urandom_range(0, 3) == 0) return (node + 1) % nodes_in_use;
      return $urandom_range(0, nodes_in_use - 1);
   endfunction

   // Make sure every node in use holds a successor inside the graph, so no
   // solve ever reads a table entry that was never written.
   task automatic fill_graph();
      int i;
      broken.delete();
      for (i = 0; i < nodes_in_use; i++)
         if (next_copy[i] >= nodes_in_use) send(ACT_LOAD, i, pick_next(i));
   endtask

   // One burst: repair earlier bad loads, a few loads (now and then out of the
   // graph or out of range), then a few queries, the first of which solves anew after any load.
   task automatic run_burst();
      int loads, asks, k, nd, sc;
      while (broken.size() > 0) begin
         nd = broken.pop_front();
         send(ACT_LOAD, nd, pick_next(nd));
      end
      loads = $urandom_range(0, 3);
      for (k = 0; k < loads; k++) begin
         nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_NODES_DEFAULT - 1)
                                         : $urandom_range(0, nodes_in_use - 1);
         if (nodes_in_use < MAX_NODES_DEFAULT && $urandom_range(0, 19) == 0) begin
            sc = $urandom_range(nodes_in_use, MAX_NODES_DEFAULT - 1);
            if (nd < nodes_in_use) broken = {broken, nd};
         end else begin
            sc = pick_next(nd);
         end
         send(ACT_LOAD, nd, sc);
      end
      asks = $urandom_range(1, 4);
      for (k = 0; k < asks; k++) begin
         nd = ($urandom_range(0, 6) == 0) ? $urandom_range(0, MAX_NODES_DEFAULT - 1)
                                         : $urandom_range(0, nodes_in_use - 1);
         send(ACT_QUERY, nd, $urandom_range(0, MAX_NODES_DEFAULT - 1));
      end
   endtask

   initial begin
      int i, phase, bursts;
      for (i = 0; i < MAX_NODES_DEFAULT; i++) next_copy[i] = MAX_NODES_DEFAULT;

      // Hold reset at the start, then release it for good.
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: a zero count clamps to a single node, which loops on itself;
      // a query far outside the graph must flag an error.
      set_nodes('0);
      send(ACT_LOAD, 0, 0);
      send(ACT_QUERY, 0, 0);
      send(ACT_QUERY, MAX_NODES_DEFAULT - 1, MAX_NODES_DEFAULT - 1);

      // Eight nodes: tail 7 -> 0 -> 1 -> 2 into the loop 3 -> 4 -> 5 -> 3,
      // plus node 6 looping on itself.
      set_nodes(11'd8);
      send(ACT_LOAD, 0, 1);
      send(ACT_LOAD, 1, 2);
      send(ACT_LOAD, 2, 3);
      send(ACT_LOAD, 3, 4);
      send(ACT_LOAD, 4, 5);
      send(ACT_LOAD, 5, 3);
      send(ACT_LOAD, 6, 6);
      send(ACT_LOAD, 7, 0);
      send(ACT_QUERY, 7, 0);
      send(ACT_QUERY, 4, 0);
      send(ACT_QUERY, 6, 0);
      send(ACT_QUERY, 0, 0);
      // Out-of-range successor poisons every query until it is repaired.
      send(ACT_LOAD, 2, MAX_NODES_DEFAULT - 1);
      send(ACT_QUERY, 6, 0);
      send(ACT_QUERY, 2, 0);
      send(ACT_LOAD, 2, 3);
      // A load to a node outside the graph is kept but changes nothing now.
      send(ACT_LOAD, MAX_NODES_DEFAULT - 1, 0);
      send(ACT_QUERY, 2, 0);

      // Random phases: a small graph first, then a full-size or clamped count.
      // Filling the full table costs about a thousand loads, so that phase gets
      // only a couple of bursts and closes the run.
      phase = 0;
      while (sent_items < TOTAL_ITEMS) begin
         bursts = $urandom_range(8, 20);
         if (phase == 1) begin
            set_nodes(11'($urandom_range(MAX_NODES_DEFAULT, 2047)));
            bursts = 2;
         end else begin
            set_nodes(11'($urandom_range(2, 64)));
         end
         fill_graph();
         for (i = 0; i < bursts; i++) run_burst();
         phase++;
      end

      drain();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/fgce_pkg.sv
sv/fgce_ram.sv
sv/fgce_solver.sv
sv/functional_graph_cycle_entry.sv
tb/functional_graph_cycle_entry_checker.sv
tb/functional_graph_cycle_entry_tb.sv
